@@ sv/serial_adc_reader_averager_unit_assert.svh @@
// Assertion macros used by the checker of the serial ADC reader averager.
// Depends on signals named clk and rst_n in the scope that uses the macros.
`ifndef SERIAL_ADC_READER_AVERAGER_UNIT_ASSERT_SVH
`define SERIAL_ADC_READER_AVERAGER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SARA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SARA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sara_pkg.sv @@
// Types, constants and the microprogram of the serial ADC reader averager.
// Used by every RTL module of the block; depends on nothing else.
package sara_pkg;

    // Fixed widths of the configuration and result fields.
    localparam int MODE_W    = 2;
    localparam int TIMEOUT_W = 20;
    localparam int COUNT_W   = 8;
    localparam int AVG_W     = 24;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_MODE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT      = 1'b1;

    // Register reset values.
    localparam logic [MODE_W-1:0]    DEFAULT_MODE_RST = 2'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 20'd500000;

    // Saturation limits of the average, as magnitudes.
    localparam logic [AVG_W-1:0] AVG_MAX     = 24'h7FFFFF;
    localparam logic [AVG_W-1:0] AVG_MIN     = 24'h800000;
    localparam logic [AVG_W:0]   AVG_NEG_LIM = 25'h0800000;

    // Microprogram addresses.
    typedef enum logic [4:0] {
        S_IDLE_GET  = 5'd0,
        S_IDLE_TST  = 5'd1,
        S_IDLE_GO   = 5'd2,
        S_IDLE_NOP  = 5'd3,
        S_WAIT_GET  = 5'd4,
        S_WAIT_TST  = 5'd5,
        S_WAIT_RDY  = 5'd6,
        S_WAIT_TO   = 5'd7,
        S_TO_EMIT   = 5'd8,
        S_WAIT_INC  = 5'd9,
        S_BH_GET    = 5'd10,
        S_BH_SHIFT  = 5'd11,
        S_BL_GET    = 5'd12,
        S_BL_TST    = 5'd13,
        S_BL_NEXT   = 5'd14,
        S_BL_ACC    = 5'd15,
        S_BL_MODE   = 5'd16,
        S_BL_PULSE  = 5'd17,
        S_FIN_TST   = 5'd18,
        S_FIN_NEXT  = 5'd19,
        S_PH_GET    = 5'd20,
        S_PH_EMIT   = 5'd21,
        S_PL_GET    = 5'd22,
        S_PL_DEC    = 5'd23,
        S_PL_TST    = 5'd24,
        S_PL_NEXT   = 5'd25,
        S_DIV_INIT  = 5'd26,
        S_DIV_STEP  = 5'd27,
        S_DIV_EMIT  = 5'd28
    } step_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_GET       = 4'd1,
        OP_START     = 4'd2,
        OP_CLR_SHIFT = 4'd3,
        OP_INC_WAIT  = 4'd4,
        OP_SHIFT     = 4'd5,
        OP_ACCUM     = 4'd6,
        OP_LOAD_MODE = 4'd7,
        OP_DEC_PULSE = 4'd8,
        OP_CLR_WAIT  = 4'd9,
        OP_DIV_INIT  = 4'd10,
        OP_DIV_STEP  = 4'd11
    } op_t;

    // Branch conditions.
    typedef enum logic [3:0] {
        C_ALWAYS    = 4'd0,
        C_START     = 4'd1,
        C_DATA_LOW  = 4'd2,
        C_TIMEOUT   = 4'd3,
        C_BITS_DONE = 4'd4,
        C_MODE_NZ   = 4'd5,
        C_LAST      = 4'd6,
        C_PULSE_NZ  = 4'd7,
        C_DIV_LAST  = 4'd8
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic  emit;
        logic  clk_lvl;
        logic  busy;
        logic  done;
        logic  tout;
        op_t   op;
        cond_t cond;
        step_t tgt_t;
        step_t tgt_f;
    } ucode_word_t;

    // Control from the sequencer to the datapath and divider.
    typedef struct packed {
        ucode_word_t word;
        logic        fire;
    } seq_ctrl_t;

    // Condition flags from the datapath to the sequencer.
    typedef struct packed {
        logic start;
        logic data_low;
        logic timeout;
        logic bits_done;
        logic mode_nz;
        logic last;
        logic pulse_nz;
        logic div_last;
    } status_t;

    // Builds one control word.
    function automatic ucode_word_t mk(
        input logic  emit,
        input logic  clk_lvl,
        input logic  busy,
        input logic  done,
        input logic  tout,
        input op_t   op,
        input cond_t cond,
        input step_t tgt_t,
        input step_t tgt_f
    );
        ucode_word_t w;
        w.emit    = emit;
        w.clk_lvl = clk_lvl;
        w.busy    = busy;
        w.done    = done;
        w.tout    = tout;
        w.op      = op;
        w.cond    = cond;
        w.tgt_t   = tgt_t;
        w.tgt_f   = tgt_f;
        return w;
    endfunction

    // The microprogram. A step with an emit bit ends one tick and writes its result.
    function automatic ucode_word_t ucode_rom(input step_t s);
        ucode_word_t w;
        case (s)
            S_IDLE_GET: w = mk(0, 0, 0, 0, 0, OP_GET,       C_ALWAYS,    S_IDLE_TST, S_IDLE_TST);
            S_IDLE_TST: w = mk(0, 0, 0, 0, 0, OP_NONE,      C_START,     S_IDLE_GO,  S_IDLE_NOP);
            S_IDLE_GO:  w = mk(1, 0, 1, 0, 0, OP_START,     C_ALWAYS,    S_WAIT_GET, S_WAIT_GET);
            S_IDLE_NOP: w = mk(1, 0, 0, 0, 0, OP_NONE,      C_ALWAYS,    S_IDLE_GET, S_IDLE_GET);
            S_WAIT_GET: w = mk(0, 0, 0, 0, 0, OP_GET,       C_ALWAYS,    S_WAIT_TST, S_WAIT_TST);
            S_WAIT_TST: w = mk(0, 0, 0, 0, 0, OP_NONE,      C_DATA_LOW,  S_WAIT_RDY, S_WAIT_TO);
            S_WAIT_RDY: w = mk(1, 0, 1, 0, 0, OP_CLR_SHIFT, C_ALWAYS,    S_BH_GET,   S_BH_GET);
            S_WAIT_TO:  w = mk(0, 0, 0, 0, 0, OP_NONE,      C_TIMEOUT,   S_TO_EMIT,  S_WAIT_INC);
            S_TO_EMIT:  w = mk(1, 0, 0, 1, 1, OP_NONE,      C_ALWAYS,    S_IDLE_GET, S_IDLE_GET);
            S_WAIT_INC: w = mk(1, 0, 1, 0, 0, OP_INC_WAIT,  C_ALWAYS,    S_WAIT_GET, S_WAIT_GET);
            S_BH_GET:   w = mk(0, 0, 0, 0, 0, OP_GET,       C_ALWAYS,    S_BH_SHIFT, S_BH_SHIFT);
            S_BH_SHIFT: w = mk(1, 1, 1, 0, 0, OP_SHIFT,     C_ALWAYS,    S_BL_GET,   S_BL_GET);
            S_BL_GET:   w = mk(0, 0, 0, 0, 0, OP_GET,       C_ALWAYS,    S_BL_TST,   S_BL_TST);
            S_BL_TST:   w = mk(0, 0, 0, 0, 0, OP_NONE,      C_BITS_DONE, S_BL_ACC,   S_BL_NEXT);
            S_BL_NEXT:  w = mk(1, 0, 1, 0, 0, OP_NONE,      C_ALWAYS,    S_BH_GET,   S_BH_GET);
            S_BL_ACC:   w = mk(0, 0, 0, 0, 0, OP_ACCUM,     C_ALWAYS,    S_BL_MODE,  S_BL_MODE);
            S_BL_MODE:  w = mk(0, 0, 0, 0, 0, OP_LOAD_MODE, C_MODE_NZ,   S_BL_PULSE, S_FIN_TST);
            S_BL_PULSE: w = mk(1, 0, 1, 0, 0, OP_NONE,      C_ALWAYS,    S_PH_GET,   S_PH_GET);
            S_FIN_TST:  w = mk(0, 0, 0, 0, 0, OP_NONE,      C_LAST,      S_DIV_INIT, S_FIN_NEXT);
            S_FIN_NEXT: w = mk(1, 0, 1, 0, 0, OP_CLR_WAIT,  C_ALWAYS,    S_WAIT_GET, S_WAIT_GET);
            S_PH_GET:   w = mk(0, 0, 0, 0, 0, OP_GET,       C_ALWAYS,    S_PH_EMIT,  S_PH_EMIT);
            S_PH_EMIT:  w = mk(1, 1, 1, 0, 0, OP_NONE,      C_ALWAYS,    S_PL_GET,   S_PL_GET);
            S_PL_GET:   w = mk(0, 0, 0, 0, 0, OP_GET,       C_ALWAYS,    S_PL_DEC,   S_PL_DEC);
            S_PL_DEC:   w = mk(0, 0, 0, 0, 0, OP_DEC_PULSE, C_ALWAYS,    S_PL_TST,   S_PL_TST);
            S_PL_TST:   w = mk(0, 0, 0, 0, 0, OP_NONE,      C_PULSE_NZ,  S_PL_NEXT,  S_FIN_TST);
            S_PL_NEXT:  w = mk(1, 0, 1, 0, 0, OP_NONE,      C_ALWAYS,    S_PH_GET,   S_PH_GET);
            S_DIV_INIT: w = mk(0, 0, 0, 0, 0, OP_DIV_INIT,  C_ALWAYS,    S_DIV_STEP, S_DIV_STEP);
            S_DIV_STEP: w = mk(0, 0, 0, 0, 0, OP_DIV_STEP,  C_DIV_LAST,  S_DIV_EMIT, S_DIV_STEP);
            S_DIV_EMIT: w = mk(1, 0, 0, 1, 0, OP_NONE,      C_ALWAYS,    S_IDLE_GET, S_IDLE_GET);
            default:    w = mk(0, 0, 0, 0, 0, OP_NONE,      C_ALWAYS,    S_IDLE_GET, S_IDLE_GET);
        endcase
        return w;
    endfunction

endpackage

@@ sv/serial_adc_reader_averager_unit.sv @@
// Serial ADC reader and averager for a two-wire 24-bit converter. Every input item
// is one pin tick and gives exactly one result item: the serial clock level, busy,
// done with the average, and a timeout flag. A microcoded sequencer runs the tick
// program one control word per cycle unless it stalls for an input item or for room
// in the output register; a tick is the fetch of the item, tests and the step that
// writes the result, and the tick that reports the average also runs the divider,
// which produces one quotient bit per cycle. The result sits in an output register,
// so the next item is taken while it waits. Configuration writes are applied at once.
module serial_adc_reader_averager_unit
    import sara_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 start_req,
    input  logic [MODE_W-1:0]    new_mode,
    input  logic [COUNT_W-1:0]   num_readings,
    input  logic                 data_level,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 clock_level,
    output logic                 busy_res,
    output logic                 done_res,
    output logic signed [AVG_W-1:0] average,
    output logic                 timed_out
);

    localparam int TW = SAMPLE_BITS + COUNT_W;

    logic [MODE_W-1:0]    default_mode;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    seq_ctrl_t            ctrl;
    status_t              status;
    logic [TW-1:0]        total;
    logic [COUNT_W-1:0]   count;
    logic                 div_last;
    logic [AVG_W-1:0]     div_avg;
    logic                 out_free;
    logic                 emit_en;

    logic                 out_valid_reg, out_valid_next;
    logic                 clock_level_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [AVG_W-1:0]     avg_reg;
    logic                 tout_reg;

    sara_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .default_mode  (default_mode),
        .timeout_ticks (timeout_ticks)
    );

    sara_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .status   (status),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    sara_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .start_req     (start_req),
        .new_mode      (new_mode),
        .num_readings  (num_readings),
        .data_level    (data_level),
        .default_mode  (default_mode),
        .timeout_ticks (timeout_ticks),
        .div_last      (div_last),
        .total         (total),
        .count         (count),
        .status        (status)
    );

    sara_divider #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .total    (total),
        .count    (count),
        .div_last (div_last),
        .avg      (div_avg)
    );

    // Output register: written by an emit step, freed when the item is taken.
    assign out_free = !out_valid_reg || out_ready;
    assign emit_en  = ctrl.fire && ctrl.word.emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; the average shows only on a done tick without timeout.
    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            clock_level_reg <= ctrl.word.clk_lvl;
            busy_reg        <= ctrl.word.busy;
            done_reg        <= ctrl.word.done;
            tout_reg        <= ctrl.word.tout;
            avg_reg         <= (ctrl.word.done && !ctrl.word.tout) ? div_avg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign clock_level = clock_level_reg;
    assign busy_res    = busy_reg;
    assign done_res    = done_reg;
    assign average     = avg_reg;
    assign timed_out   = tout_reg;

endmodule

@@ sv/sara_cfg.sv @@
// Configuration registers of the serial ADC reader averager on an APB-style port.
// Depends on sara_pkg for register indexes, widths and reset values.
module sara_cfg
    import sara_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    output logic [MODE_W-1:0]    default_mode,
    output logic [TIMEOUT_W-1:0] timeout_ticks
);

    logic [MODE_W-1:0]    default_mode_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Registers are word aligned; the low address bits are ignored.
    assign reg_idx = paddr[2 +: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_mode_reg <= DEFAULT_MODE_RST;
            timeout_reg      <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEFAULT_MODE: default_mode_reg <= pwdata[MODE_W-1:0];
                REG_TIMEOUT:      timeout_reg      <= pwdata[TIMEOUT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        case (reg_idx)
            REG_DEFAULT_MODE: prdata = PDATA_W'(default_mode_reg);
            REG_TIMEOUT:      prdata = PDATA_W'(timeout_reg);
            default:          prdata = '0;
        endcase
    end

    assign default_mode  = default_mode_reg;
    assign timeout_ticks = timeout_reg;

endmodule

@@ sv/sara_divider.sv @@
// Iterative signed divider for the final average, one quotient bit per cycle.
// Depends on sara_pkg; driven by the sequencer's control word.
module sara_divider
    import sara_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  seq_ctrl_t                    ctrl,
    input  logic [SAMPLE_BITS+COUNT_W-1:0] total,
    input  logic [COUNT_W-1:0]           count,
    output logic                         div_last,
    output logic [AVG_W-1:0]             avg
);

    localparam int MW = SAMPLE_BITS + COUNT_W;
    localparam int CW = $clog2(MW);

    logic [MW-1:0]      quo_reg, quo_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] div_reg, div_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic [COUNT_W:0]   rem_sh;
    logic [COUNT_W:0]   rem_diff;
    logic               ge;
    logic [MW-1:0]      neg_q;
    logic               init_en;
    logic               step_en;

    assign init_en = ctrl.fire && (ctrl.word.op == OP_DIV_INIT);
    assign step_en = ctrl.fire && (ctrl.word.op == OP_DIV_STEP);

    // One restoring step: bring down the next dividend bit and try the subtract.
    assign rem_sh   = {rem_reg, quo_reg[MW-1]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign ge       = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (init_en)
        begin
            neg_next = total[MW-1];
            quo_next = total[MW-1] ? (~total + MW'(1)) : total;
            rem_next = '0;
            div_next = (count == '0) ? COUNT_W'(1) : count;
            cnt_next = CW'(MW - 1);
        end
        else if (step_en)
        begin
            rem_next = ge ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
            quo_next = {quo_reg[MW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign div_last = (cnt_reg == '0);

    // Restore the sign and saturate to the 24-bit result range.
    assign neg_q = ~quo_reg + MW'(1);

    always_comb
    begin
        if (!neg_reg)
        begin
            avg = (quo_reg > MW'(AVG_MAX)) ? AVG_MAX : quo_reg[AVG_W-1:0];
        end
        else
        begin
            avg = (quo_reg > MW'(AVG_NEG_LIM)) ? AVG_MIN : neg_q[AVG_W-1:0];
        end
    end

endmodule

@@ sv/sara_datapath.sv @@
// Datapath of the serial ADC reader averager: item latch, counters, shifter, accumulator.
// Depends on sara_pkg; executes the operation of the current control word.
module sara_datapath
    import sara_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  seq_ctrl_t                      ctrl,
    input  logic                           start_req,
    input  logic [MODE_W-1:0]              new_mode,
    input  logic [COUNT_W-1:0]             num_readings,
    input  logic                           data_level,
    input  logic [MODE_W-1:0]              default_mode,
    input  logic [TIMEOUT_W-1:0]           timeout_ticks,
    input  logic                           div_last,
    output logic [SAMPLE_BITS+COUNT_W-1:0] total,
    output logic [COUNT_W-1:0]             count,
    output status_t                        status
);

    localparam int TW  = SAMPLE_BITS + COUNT_W;
    localparam int BCW = $clog2(SAMPLE_BITS + 1);

    logic                   start_reg, start_next;
    logic [MODE_W-1:0]      nmode_reg, nmode_next;
    logic [COUNT_W-1:0]     nread_reg, nread_next;
    logic                   data_reg, data_next;
    logic [TIMEOUT_W-1:0]   wait_reg, wait_next;
    logic [SAMPLE_BITS-1:0] shift_reg, shift_next;
    logic [BCW-1:0]         bitcnt_reg, bitcnt_next;
    logic [MODE_W-1:0]      pulse_reg, pulse_next;
    logic [COUNT_W-1:0]     left_reg, left_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [MODE_W-1:0]      last_mode_reg, last_mode_next;
    logic [MODE_W-1:0]      mode_sel;
    logic [TW-1:0]          sample_ext;

    // The last reading uses the mode latched at start when nonzero.
    assign mode_sel = ((left_reg == '0) && (last_mode_reg != '0)) ? last_mode_reg : default_mode;
    assign sample_ext = {{COUNT_W{shift_reg[SAMPLE_BITS-1]}}, shift_reg};

    // Next values for the operation of the current step.
    always_comb
    begin
        start_next     = start_reg;
        nmode_next     = nmode_reg;
        nread_next     = nread_reg;
        data_next      = data_reg;
        wait_next      = wait_reg;
        shift_next     = shift_reg;
        bitcnt_next    = bitcnt_reg;
        pulse_next     = pulse_reg;
        left_next      = left_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        last_mode_next = last_mode_reg;
        if (ctrl.fire)
        begin
            case (ctrl.word.op)
                OP_GET:
                begin
                    start_next = start_req;
                    nmode_next = new_mode;
                    nread_next = num_readings;
                    data_next  = data_level;
                end
                OP_START:
                begin
                    left_next      = (nread_reg == '0) ? COUNT_W'(1) : nread_reg;
                    last_mode_next = nmode_reg;
                    total_next     = '0;
                    count_next     = '0;
                    wait_next      = '0;
                end
                OP_CLR_SHIFT:
                begin
                    shift_next  = '0;
                    bitcnt_next = '0;
                end
                OP_INC_WAIT:
                begin
                    wait_next = wait_reg + TIMEOUT_W'(1);
                end
                OP_SHIFT:
                begin
                    shift_next  = {shift_reg[SAMPLE_BITS-2:0], data_reg};
                    bitcnt_next = bitcnt_reg + BCW'(1);
                end
                OP_ACCUM:
                begin
                    total_next = total_reg + sample_ext;
                    count_next = count_reg + COUNT_W'(1);
                    left_next  = left_reg - COUNT_W'(1);
                end
                OP_LOAD_MODE:
                begin
                    pulse_next = mode_sel;
                end
                OP_DEC_PULSE:
                begin
                    pulse_next = pulse_reg - MODE_W'(1);
                end
                OP_CLR_WAIT:
                begin
                    wait_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= 1'b0;
            nmode_reg     <= '0;
            nread_reg     <= '0;
            data_reg      <= 1'b0;
            wait_reg      <= '0;
            shift_reg     <= '0;
            bitcnt_reg    <= '0;
            pulse_reg     <= '0;
            left_reg      <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            last_mode_reg <= '0;
        end
        else
        begin
            start_reg     <= start_next;
            nmode_reg     <= nmode_next;
            nread_reg     <= nread_next;
            data_reg      <= data_next;
            wait_reg      <= wait_next;
            shift_reg     <= shift_next;
            bitcnt_reg    <= bitcnt_next;
            pulse_reg     <= pulse_next;
            left_reg      <= left_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            last_mode_reg <= last_mode_next;
        end
    end

    // Condition flags for the sequencer's branches.
    always_comb
    begin
        status.start     = start_reg;
        status.data_low  = !data_reg;
        status.timeout   = (wait_reg >= timeout_ticks);
        status.bits_done = (bitcnt_reg >= BCW'(SAMPLE_BITS));
        status.mode_nz   = (mode_sel != '0);
        status.last      = (left_reg == '0);
        status.pulse_nz  = (pulse_reg != '0);
        status.div_last  = div_last;
    end

    assign total = total_reg;
    assign count = count_reg;

endmodule

@@ sv/sara_sequencer.sv @@
// Microcode sequencer: step counter, control word fetch and conditional jumps.
// Depends on sara_pkg for the microprogram and the control and status structs.
module sara_sequencer
    import sara_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_free,
    input  status_t   status,
    output logic      in_ready,
    output seq_ctrl_t ctrl
);

    step_t       step_reg, step_next;
    ucode_word_t word;
    logic        stall;
    logic        cond_ok;

    // Control word outputs and the stall rule: wait for an item, or for room to emit.
    always_comb
    begin
        word      = ucode_rom(step_reg);
        in_ready  = (word.op == OP_GET);
        stall     = ((word.op == OP_GET) && !in_valid) || (word.emit && !out_free);
        ctrl.word = word;
        ctrl.fire = !stall;
    end

    // Branch condition select and next step.
    always_comb
    begin
        case (word.cond)
            C_ALWAYS:    cond_ok = 1'b1;
            C_START:     cond_ok = status.start;
            C_DATA_LOW:  cond_ok = status.data_low;
            C_TIMEOUT:   cond_ok = status.timeout;
            C_BITS_DONE: cond_ok = status.bits_done;
            C_MODE_NZ:   cond_ok = status.mode_nz;
            C_LAST:      cond_ok = status.last;
            C_PULSE_NZ:  cond_ok = status.pulse_nz;
            C_DIV_LAST:  cond_ok = status.div_last;
            default:     cond_ok = 1'b1;
        endcase
        if (stall)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = cond_ok ? word.tgt_t : word.tgt_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE_GET;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ sv/serial_adc_reader_averager_unit_checker.sv @@
// Port-level checker for the serial ADC reader averager, bound to the top level.
// Depends on the assertion macros in serial_adc_reader_averager_unit_assert.svh.
`include "serial_adc_reader_averager_unit_assert.svh"

module serial_adc_reader_averager_unit_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              clock_level,
    input logic              busy_res,
    input logic              done_res,
    input logic signed [23:0] average,
    input logic              timed_out
);

    // A stalled result item keeps its average.
    `SARA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(average), "result item changed while stalled")

    // The tick that reports done is never a busy tick.
    `SARA_ASSERT_IMPLY(a_done_not_busy, out_valid && done_res, !busy_res, "done reported on a busy tick")

    // A timeout comes only with done and carries a zero average.
    `SARA_ASSERT_IMPLY(a_timeout_done, out_valid && timed_out, done_res && (average == 24'sd0), "timeout without done or with nonzero average")

    // The serial clock is driven high only inside a read sequence, and never with an average.
    `SARA_ASSERT_IMPLY(a_clock_busy, out_valid && clock_level, busy_res && (average == 24'sd0), "serial clock high outside a sequence")

endmodule

bind serial_adc_reader_averager_unit serial_adc_reader_averager_unit_checker u_checker (.*);
